// File: hdl/erm_pkg.sv
package erm_pkg;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
  } out_item_t;

  localparam int WORK_Q = 30;
  localparam int FULL_TURN = 23040;
  localparam int HALF_TURN = 11520;
  localparam int QUARTER_TURN = 5760;
  localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;
  localparam longint RAD_IN_ANGLE_UNITS = 64'd240315917;

  function automatic logic signed [33:0] atan_step(input int i);
    logic signed [33:0] v;
    begin
      case (i)
        0: v = 34'sd188743680;
        1: v = 34'sd111421900;
        2: v = 34'sd58872272;
        3: v = 34'sd29884485;
        4: v = 34'sd15000234;
        5: v = 34'sd7507429;
        6: v = 34'sd3754631;
        7: v = 34'sd1877430;
        8: v = 34'sd938729;
        9: v = 34'sd469366;
        10: v = 34'sd234683;
        11: v = 34'sd117342;
        12: v = 34'sd58671;
        13: v = 34'sd29335;
        14: v = 34'sd14668;
        15: v = 34'sd7334;
        default: v = 34'((RAD_IN_ANGLE_UNITS + (64'd1 << (i - 1))) >> i);
      endcase
      return v;
    end
  endfunction

endpackage

// File: hdl/erm_cordic.sv
// Pipelined sin/cos for one angle: reduce, then one CORDIC iteration per stage.
module erm_cordic #(
  parameter int TRIG_STAGES = 16
) (
  input  logic                clk,
  input  logic signed [15:0]  angle,
  output logic signed [33:0]  sin_q,
  output logic signed [33:0]  cos_q
);

  localparam int N = TRIG_STAGES;

  logic signed [33:0] x_r [0:N];
  logic signed [33:0] y_r [0:N];
  logic signed [33:0] z_r [0:N];
  logic               flip_r [0:N];
  logic signed [15:0] red_r;
  logic               flip0_r;

  logic signed [15:0] m;
  logic signed [15:0] a_nxt;
  logic               fl_nxt;

  // stage A: wrap modulo one turn, fold into +-90 degrees
  always_comb begin
    m = angle;
    if (m >= 16'sd23040) m = m - 16'sd23040;
    else if (m < -16'sd23040) m = m + 16'sd23040;
    if (m > 16'sd11520) m = m - 16'sd23040;
    else if (m < -16'sd11520) m = m + 16'sd23040;
    fl_nxt = 1'b0;
    a_nxt = m;
    if (m > 16'sd5760) begin
      a_nxt = m - 16'sd11520;
      fl_nxt = 1'b1;
    end else if (m < -16'sd5760) begin
      a_nxt = m + 16'sd11520;
      fl_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    red_r <= a_nxt;
    flip0_r <= fl_nxt;
    x_r[0] <= erm_pkg::CORDIC_INV_GAIN;
    y_r[0] <= '0;
    z_r[0] <= 34'(red_r) <<< 16;
    flip_r[0] <= flip0_r;
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (!z_r[i][33]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - erm_pkg::atan_step(i);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + erm_pkg::atan_step(i);
      end
      flip_r[i+1] <= flip_r[i];
    end
  end

  always_ff @(posedge clk) begin
    sin_q <= flip_r[N] ? -y_r[N] : y_r[N];
    cos_q <= flip_r[N] ? -x_r[N] : x_r[N];
  end

endmodule

// File: hdl/euler_rotation_matrix.sv
// Euler-angle rotation matrix R = A*B*G (rotate x, then y, then z).
//
// Input: pulse start with in_item (three angles, degrees * 64) while busy is
// low; busy stays low, so a new angle triple can enter every clock cycle.
// Output: out_valid is high for exactly one cycle with the nine Q1.FRAC_BITS
// entries on out_item. The receiver cannot stall; results are never held.
// The folded angle is registered, then loaded into the CORDIC, followed by
// one CORDIC iteration per stage, the sign fix, then first products, second
// products, sums, and the output rounding register.
// Throughput: one item per cycle, set by the fully pipelined CORDIC lanes.
// Reset clears only the valid pipeline; data registers need no reset.
module euler_rotation_matrix #(
  parameter int FRAC_BITS = 14,
  parameter int TRIG_STAGES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  erm_pkg::in_item_t   in_item,
  output logic                out_valid,
  output erm_pkg::out_item_t  out_item
);

  localparam int LAT = TRIG_STAGES + 7;
  localparam int SH = erm_pkg::WORK_Q - FRAC_BITS;

  logic [LAT-1:0] vld_r;
  logic signed [33:0] sa, ca, sb, cb, sg, cg;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[LAT-2:0], start};
  end
  assign out_valid = vld_r[LAT-1];

  erm_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_x (.clk, .angle(in_item.angle_x),
    .sin_q(sa), .cos_q(ca));
  erm_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_y (.clk, .angle(in_item.angle_y),
    .sin_q(sb), .cos_q(cb));
  erm_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_z (.clk, .angle(in_item.angle_z),
    .sin_q(sg), .cos_q(cg));

  function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    logic signed [67:0] p;
    begin
      p = a * b + (68'sd1 <<< (erm_pkg::WORK_Q - 1));
      return 34'(p >>> erm_pkg::WORK_Q);
    end
  endfunction

  function automatic logic signed [15:0] to_out(input logic signed [35:0] v);
    logic signed [35:0] r;
    logic signed [35:0] one;
    begin
      one = 36'sd1 <<< FRAC_BITS;
      r = (SH > 0) ? ((v + (36'sd1 <<< (SH - 1))) >>> SH) : v;
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[15:0];
    end
  endfunction

  // stage 1: first products, delay trig terms
  logic signed [33:0] sasb_r, casb_r, ca1_r, sa1_r, cb1_r, sb1_r, sg1_r, cg1_r;
  always_ff @(posedge clk) begin
    sasb_r <= mulq(sa, sb);
    casb_r <= mulq(ca, sb);
    ca1_r <= ca; sa1_r <= sa; cb1_r <= cb; sb1_r <= sb; sg1_r <= sg; cg1_r <= cg;
  end

  // stage 2: all second-level products
  logic signed [33:0] p00_r, p01_r, p02_r, p10a_r, p10b_r, p11a_r, p11b_r, p12_r;
  logic signed [33:0] p20a_r, p20b_r, p21a_r, p21b_r, p22_r;
  always_ff @(posedge clk) begin
    p00_r <= mulq(cb1_r, cg1_r);
    p01_r <= -mulq(cb1_r, sg1_r);
    p02_r <= -sb1_r;
    p10a_r <= mulq(ca1_r, sg1_r);
    p10b_r <= mulq(sasb_r, cg1_r);
    p11a_r <= mulq(sasb_r, sg1_r);
    p11b_r <= mulq(ca1_r, cg1_r);
    p12_r <= -mulq(sa1_r, cb1_r);
    p20a_r <= mulq(casb_r, cg1_r);
    p20b_r <= mulq(sa1_r, sg1_r);
    p21a_r <= mulq(sa1_r, cg1_r);
    p21b_r <= mulq(casb_r, sg1_r);
    p22_r <= mulq(ca1_r, cb1_r);
  end

  // stage 3: sums
  logic signed [35:0] s_r [0:8];
  always_ff @(posedge clk) begin
    s_r[0] <= 36'(p00_r);
    s_r[1] <= 36'(p01_r);
    s_r[2] <= 36'(p02_r);
    s_r[3] <= 36'(p10a_r) - 36'(p10b_r);
    s_r[4] <= 36'(p11a_r) + 36'(p11b_r);
    s_r[5] <= 36'(p12_r);
    s_r[6] <= 36'(p20a_r) + 36'(p20b_r);
    s_r[7] <= 36'(p21a_r) - 36'(p21b_r);
    s_r[8] <= 36'(p22_r);
  end

  // stage 4: round and saturate
  always_ff @(posedge clk) begin
    out_item.r00 <= to_out(s_r[0]);
    out_item.r01 <= to_out(s_r[1]);
    out_item.r02 <= to_out(s_r[2]);
    out_item.r10 <= to_out(s_r[3]);
    out_item.r11 <= to_out(s_r[4]);
    out_item.r12 <= to_out(s_r[5]);
    out_item.r20 <= to_out(s_r[6]);
    out_item.r21 <= to_out(s_r[7]);
    out_item.r22 <= to_out(s_r[8]);
  end

endmodule

// File: hdl/erm_checker.sv
module erm_checker #(
  parameter int LAT = 23
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input erm_pkg::out_item_t out_item
);

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.r00 <= 16'sd16384 && out_item.r00 >= -16'sd16384))
    else $error("r00 out of range");

  a_r22_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.r22 <= 16'sd16384 && out_item.r22 >= -16'sd16384))
    else $error("r22 out of range");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result right after reset");

  // every transfer comes out after the fixed pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after transfer");

endmodule

bind euler_rotation_matrix erm_checker #(.LAT(TRIG_STAGES + 7)) u_erm_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_item
);

// File: tb/rotation_checker.sv
module rotation_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  erm_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  erm_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 14;
  localparam int STAGES = 16;

  erm_pkg::out_item_t matrix_q[$];
  int report_count;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint arctan_units(int i);
    longint tab[16] = '{188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
                        3754631, 1877430, 938729, 469366, 234683, 117342, 58671,
                        29335, 14668, 7334};
    if (i < 16) return tab[i];
    return (longint'(240315917) + (longint'(1) << (i - 1))) >> i;
  endfunction

  task automatic sin_cos(logic signed [15:0] ang, output longint s, output longint c);
    int a;
    bit flip;
    longint x, y, z, dx, dy;
    a = ang;
    flip = 0;
    a = a % erm_pkg::FULL_TURN;
    if (a < 0) a += erm_pkg::FULL_TURN;
    if (a > erm_pkg::HALF_TURN) a -= erm_pkg::FULL_TURN;
    if (a > erm_pkg::QUARTER_TURN) begin
      a -= erm_pkg::HALF_TURN;
      flip = 1;
    end else if (a < -erm_pkg::QUARTER_TURN) begin
      a += erm_pkg::HALF_TURN;
      flip = 1;
    end
    x = 652032874;
    y = 0;
    z = longint'(a) * 65536;
    for (int i = 0; i < STAGES; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_units(i);
      end else begin
        x += dx; y -= dy; z += arctan_units(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endtask

  function automatic longint qmul(longint a, longint b);
    return floor_shr(a * b + (longint'(1) << 29), 30);
  endfunction

  function automatic logic [15:0] to_q14(longint v);
    longint one;
    one = longint'(1) << FRAC;
    v = floor_shr(v + (longint'(1) << (29 - FRAC)), 30 - FRAC);
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v[15:0];
  endfunction

  task automatic predict_rotation(erm_pkg::in_item_t it);
    longint sa, ca, sb, cb, sg, cg, sasb, casb;
    erm_pkg::out_item_t r;
    sin_cos(it.angle_x, sa, ca);
    sin_cos(it.angle_y, sb, cb);
    sin_cos(it.angle_z, sg, cg);
    sasb = qmul(sa, sb);
    casb = qmul(ca, sb);
    r.r00 = to_q14(qmul(cb, cg));
    r.r01 = to_q14(-qmul(cb, sg));
    r.r02 = to_q14(-sb);
    r.r10 = to_q14(qmul(ca, sg) - qmul(sasb, cg));
    r.r11 = to_q14(qmul(sasb, sg) + qmul(ca, cg));
    r.r12 = to_q14(-qmul(sa, cb));
    r.r20 = to_q14(qmul(casb, cg) + qmul(sa, sg));
    r.r21 = to_q14(qmul(sa, cg) - qmul(casb, sg));
    r.r22 = to_q14(qmul(ca, cb));
    matrix_q.push_back(r);
  endtask

  initial begin
    fail_count = 0;
    report_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    erm_pkg::out_item_t want;
    if (rst_n && start && !busy) predict_rotation(in_item);
    if (rst_n && out_valid) begin
      if (matrix_q.size() == 0) begin
        fail_count++;
        if (report_count < 10) begin
          report_count++;
          $display("unexpected result %h", out_item);
        end
      end else begin
        want = matrix_q.pop_front();
        if (want !== out_item) begin
          fail_count++;
          if (report_count < 10) begin
            report_count++;
            $display("mismatch: expected %h actual %h", want, out_item);
          end
        end
      end
    end
    pending = matrix_q.size();
  end
endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 23;
  localparam int WATCHDOG = 5000;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic out_valid;
  erm_pkg::in_item_t in_item = '0;
  erm_pkg::out_item_t out_item;
  int fail_count, pending;
  int idle_pct;
  int quiet_cycles;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  euler_rotation_matrix dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  rotation_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("FAIL euler_rotation_matrix");
      $finish;
    end
  end

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 8) * 2880 - 11520);
      2: return 16'($urandom_range(0, 46080) - 23040);
      default: return 16'($urandom_range(0, 46080) - 23040);
    endcase
  endfunction

  // hold start until the transfer happens
  task automatic send_angles(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    while (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    in_item <= '{angle_x: ax, angle_y: ay, angle_z: az};
    start <= 1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  initial begin
    logic [15:0] edge_vals[14] = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'h0001,
      16'd5760, -16'sd5760, 16'd11520, -16'sd11520, 16'd23040, -16'sd23040,
      16'd2880, 16'd5761, 16'h5555};
    quiet_cycles = 0;
    idle_pct = 0;
    repeat (11) @(negedge clk);
    rst_n = 1;
    for (int i = 0; i < 14; i++)
      send_angles(edge_vals[i], edge_vals[13 - i], edge_vals[(i * 5) % 14]);
    send_angles(16'hffff, 16'hffff, 16'hffff);
    send_angles(16'h8000, 16'h8000, 16'h8000);
    send_angles(16'h7fff, 16'h7fff, 16'h7fff);
    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 1) ? 61 : (p == 3) ? 9 : 0;
      for (int n = 0; n < 435; n++) send_angles(pick_angle(), pick_angle(), pick_angle());
    end
    start <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    if (fail_count == 0) $display("PASS euler_rotation_matrix");
    else $display("FAIL euler_rotation_matrix");
    $finish;
  end
endmodule

// File: filelist.f
hdl/erm_pkg.sv
hdl/erm_cordic.sv
hdl/euler_rotation_matrix.sv
hdl/erm_checker.sv
tb/rotation_checker.sv
tb/testbench.sv
